// ===== rtl/aimd_window_admission_controller_defines.svh =====
// Assertion macros for the AIMD admission controller.
// Included by every RTL file that carries concurrent assertions.
`ifndef AIMD_WINDOW_ADMISSION_CONTROLLER_DEFINES_SVH
`define AIMD_WINDOW_ADMISSION_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define AIMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define AIMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AIMD_ASSERT(lbl, clk, rst_n, prop, msg)
`define AIMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/aimd_pkg.sv =====
// Shared types, codes and helpers for the AIMD admission controller.
// No dependencies; imported by every module of the block.
package aimd_pkg;

    typedef logic [6:0]  t_win;
    typedef logic [15:0] t_cnt;
    typedef logic [63:0] t_time;

    localparam t_cnt  CntTop  = '1;
    localparam t_time TimeTop = '1;

    // Event kinds; codes 6 and 7 act as a metrics read
    typedef enum logic [2:0] {
        KIND_RESERVE    = 3'd0,
        KIND_CONFIRM    = 3'd1,
        KIND_CANCEL     = 3'd2,
        KIND_COMPLETION = 3'd3,
        KIND_METRICS    = 3'd4,
        KIND_INIT       = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_INITIAL_WINDOW    = 2'd0,
        CFG_WINDOW_LIMIT      = 2'd1,
        CFG_DECREASE_COOLDOWN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_win  initial_window;
        t_win  window_limit;
        t_time decrease_cooldown;
    } t_cfg;

    // Controller state seen by the integrator, plus the accepted-init strobe
    typedef struct packed {
        t_win window;
        t_cnt outstanding;
        logic init_ok;
    } t_ctrl_view;

    typedef struct packed {
        logic granted;
        logic status;
        t_win window;
        t_cnt outstanding;
        t_cnt peak;
    } t_ctrl_res;

    typedef struct packed {
        t_time window_sum;
        t_time inflight_sum;
        t_time observed;
    } t_sums;

    function automatic t_time sat_add64(input t_time a, input t_time b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? TimeTop : s[63:0];
    endfunction

endpackage

// ===== rtl/aimd_window_admission_controller.sv =====
// An accepted event is held in the input register and is processed into the result
// register once the result slot is free or being drained.
// Throughput: one event per cycle unless the result channel stalls; the input register and
// the result register form a two-stage pipe, and all state updates when the result loads.
// Reset (synchronous, active low): window 1, counters and integrals 0, latched limit 64,
// configuration registers at initial 1, limit 64, cooldown 0.
`include "aimd_window_admission_controller_defines.svh"
module aimd_window_admission_controller #(
    parameter int unsigned MAX_WINDOW = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    // event channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_kind,
    input  aimd_pkg::t_time   i_timestamp,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_granted,
    output logic              o_status,
    output aimd_pkg::t_win    o_window_now,
    output aimd_pkg::t_cnt    o_inflight_now,
    output aimd_pkg::t_cnt    o_peak_inflight,
    output aimd_pkg::t_time   o_window_time_sum,
    output aimd_pkg::t_time   o_inflight_time_sum,
    output aimd_pkg::t_time   o_observed_time
);
    import aimd_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [2:0] r_in_kind;
    t_time      r_in_ts;
    logic       r_res_valid;
    t_ctrl_res  r_res_ctrl;
    t_sums      r_res_sums;

    logic       w_step;
    t_ctrl_view w_view;
    t_ctrl_res  w_ctrl_res;
    t_sums      w_sums;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_window    <= 7'd1;
            r_cfg.window_limit      <= 7'd64;
            r_cfg.decrease_cooldown <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INITIAL_WINDOW:    r_cfg.initial_window    <= i_cfg_data[6:0];
                CFG_WINDOW_LIMIT:      r_cfg.window_limit      <= i_cfg_data[6:0];
                CFG_DECREASE_COOLDOWN: r_cfg.decrease_cooldown <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the held event is processed when the result slot is free or being drained
    assign w_step     = r_in_valid && (!r_res_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_kind <= i_kind;
            r_in_ts   <= i_timestamp;
        end
    end

    aimd_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_kind  (r_in_kind),
        .i_now   (r_in_ts),
        .i_cfg   (r_cfg),
        .o_view  (w_view),
        .o_res   (w_ctrl_res)
    );

    aimd_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_now   (r_in_ts),
        .i_view  (w_view),
        .o_next  (w_sums)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_step) begin
            r_res_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res_ctrl <= w_ctrl_res;
            r_res_sums <= w_sums;
        end
    end

    assign o_out_valid         = r_res_valid;
    assign o_granted           = r_res_ctrl.granted;
    assign o_status            = r_res_ctrl.status;
    assign o_window_now        = r_res_ctrl.window;
    assign o_inflight_now      = r_res_ctrl.outstanding;
    assign o_peak_inflight     = r_res_ctrl.peak;
    assign o_window_time_sum   = r_res_sums.window_sum;
    assign o_inflight_time_sum = r_res_sums.inflight_sum;
    assign o_observed_time     = r_res_sums.observed;

    `AIMD_ASSERT_NEXT(a_step_fills_result, i_clk, i_rst_n, w_step, r_res_valid,
        "processed transaction produced no result")
    `AIMD_ASSERT_NEXT(a_held_event_kept, i_clk, i_rst_n, r_in_valid && !w_step,
        r_in_valid && $stable(r_in_ts) && $stable(r_in_kind),
        "stalled event lost or changed")

endmodule

// ===== rtl/aimd_integ.sv =====
// Time integrals of window and in-flight count, saturating at 2^64-1.
// Depends on aimd_pkg; state comes from aimd_ctrl through t_ctrl_view.
`include "aimd_window_admission_controller_defines.svh"
module aimd_integ (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  aimd_pkg::t_time     i_now,
    input  aimd_pkg::t_ctrl_view i_view,
    output aimd_pkg::t_sums     o_next
);
    import aimd_pkg::*;

    t_time       r_last_time;
    t_sums       r_sums;
    t_sums       n_sums;
    t_time       w_delta;
    logic        w_forward;
    logic [70:0] w_win_prod;
    logic [79:0] w_inf_prod;
    t_time       w_win_term;
    t_time       w_inf_term;

    always_comb begin
        w_forward  = (i_now >= r_last_time);
        w_delta    = i_now - r_last_time;
        w_win_prod = {64'd0, i_view.window} * {7'd0, w_delta};
        w_inf_prod = {64'd0, i_view.outstanding} * {16'd0, w_delta};
        w_win_term = (|w_win_prod[70:64]) ? TimeTop : w_win_prod[63:0];
        w_inf_term = (|w_inf_prod[79:64]) ? TimeTop : w_inf_prod[63:0];

        n_sums = r_sums;
        // a timestamp that goes backwards only moves the reference time
        if (w_forward) begin
            n_sums.window_sum   = sat_add64(r_sums.window_sum, w_win_term);
            n_sums.inflight_sum = sat_add64(r_sums.inflight_sum, w_inf_term);
            n_sums.observed     = sat_add64(r_sums.observed, w_delta);
        end
        if (i_view.init_ok) begin
            n_sums = '0;
        end
    end

    assign o_next = n_sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_sums      <= '0;
        end else if (i_step) begin
            // both the normal and the backwards case end at the event time
            r_last_time <= i_now;
            r_sums      <= n_sums;
        end
    end

    `AIMD_ASSERT_NEXT(a_init_clears, i_clk, i_rst_n, i_step && i_view.init_ok,
        r_sums == '0, "accepted init did not clear the integrals")

endmodule

// ===== rtl/aimd_ctrl.sv =====
// AIMD window, reservation and in-flight counters, event decode.
// Depends on aimd_pkg.
`include "aimd_window_admission_controller_defines.svh"
module aimd_ctrl #(
    parameter int unsigned MAX_WINDOW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [2:0]           i_kind,
    input  aimd_pkg::t_time      i_now,
    input  aimd_pkg::t_cfg       i_cfg,
    output aimd_pkg::t_ctrl_view o_view,
    output aimd_pkg::t_ctrl_res  o_res
);
    import aimd_pkg::*;

    // the window field is 7 bits, so a larger ceiling never binds
    localparam t_win MaxWin = (MAX_WINDOW > 127) ? 7'd127 : 7'(MAX_WINDOW);

    t_win  r_window, n_window;
    t_cnt  r_out, n_out;
    t_cnt  r_res, n_res;
    t_cnt  r_ack, n_ack;
    t_cnt  r_peak, n_peak;
    t_time r_last_halve, n_last_halve;
    t_win  r_lim, n_lim;
    t_time r_cool, n_cool;

    logic  w_granted;
    logic  w_status;
    logic  w_init_ok;
    t_win  w_eff_lim;
    t_cnt  w_ack_inc;
    t_win  w_half;

    always_comb begin
        w_eff_lim = (i_cfg.window_limit < MaxWin) ? i_cfg.window_limit : MaxWin;
        w_ack_inc = (r_ack != CntTop) ? r_ack + 16'd1 : r_ack;
        w_half    = (r_window[6:1] == 6'd0) ? 7'd1 : {1'b0, r_window[6:1]};

        n_window     = r_window;
        n_out        = r_out;
        n_res        = r_res;
        n_ack        = r_ack;
        n_peak       = r_peak;
        n_last_halve = r_last_halve;
        n_lim        = r_lim;
        n_cool       = r_cool;
        w_granted    = 1'b0;
        w_status     = 1'b0;
        w_init_ok    = 1'b0;

        case (i_kind)
            KIND_RESERVE: begin
                if ({1'b0, r_out} + {1'b0, r_res} < {10'd0, r_window}) begin
                    if (r_res != CntTop) n_res = r_res + 16'd1;
                    w_granted = 1'b1;
                end
            end
            KIND_CONFIRM: begin
                if (r_res != '0) n_res = r_res - 16'd1;
                if (r_out != CntTop) n_out = r_out + 16'd1;
                if (n_out > r_peak) n_peak = n_out;
            end
            KIND_CANCEL: begin
                if (r_res != '0) n_res = r_res - 16'd1;
                // elapsed since last halving wraps modulo 2^64
                if (i_now - r_last_halve >= r_cool) begin
                    n_window     = w_half;
                    n_ack        = '0;
                    n_last_halve = i_now;
                end
            end
            KIND_COMPLETION: begin
                if (r_out != '0) n_out = r_out - 16'd1;
                n_ack = w_ack_inc;
                if (w_ack_inc >= {9'd0, r_window}) begin
                    if (r_window < r_lim) n_window = r_window + 7'd1;
                    n_ack = '0;
                end
            end
            KIND_INIT: begin
                if (i_cfg.initial_window == '0 || i_cfg.initial_window > w_eff_lim) begin
                    w_status = 1'b1;
                end else begin
                    w_init_ok    = 1'b1;
                    n_window     = i_cfg.initial_window;
                    n_lim        = w_eff_lim;
                    n_cool       = i_cfg.decrease_cooldown;
                    n_out        = '0;
                    n_res        = '0;
                    n_ack        = '0;
                    n_peak       = '0;
                    n_last_halve = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_view = '{window: r_window, outstanding: r_out, init_ok: w_init_ok};
    assign o_res  = '{granted: w_granted, status: w_status, window: n_window,
                      outstanding: n_out, peak: n_peak};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= 7'd1;
            r_out        <= '0;
            r_res        <= '0;
            r_ack        <= '0;
            r_peak       <= '0;
            r_last_halve <= '0;
            r_lim        <= 7'd64;
            r_cool       <= '0;
        end else if (i_step) begin
            r_window     <= n_window;
            r_out        <= n_out;
            r_res        <= n_res;
            r_ack        <= n_ack;
            r_peak       <= n_peak;
            r_last_halve <= n_last_halve;
            r_lim        <= n_lim;
            r_cool       <= n_cool;
        end
    end

    `AIMD_ASSERT(a_window_nonzero, i_clk, i_rst_n, r_window != '0,
        "window dropped to zero")
    `AIMD_ASSERT(a_window_capped, i_clk, i_rst_n, r_window <= r_lim,
        "window above latched limit")
    `AIMD_ASSERT_NEXT(a_additive_step, i_clk, i_rst_n,
        i_step && i_kind == KIND_COMPLETION,
        r_window == $past(r_window) || r_window == $past(r_window) + 7'd1,
        "completion moved window by more than one")

endmodule
